// File: hdl/cfp_pkg.sv
package cfp_pkg;

  // Frame format limits
  localparam int unsigned MAX_DATA = 32;
  localparam int unsigned ID_COUNT = 16;
  localparam int unsigned LEN_W    = $clog2(MAX_DATA + 1);
  localparam int unsigned POS_W    = $clog2(MAX_DATA);
  localparam logic [7:0]  START_BYTE = 8'hFE;

  // Command queue between parser and emitter
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Configuration register indexes
  localparam logic [7:0] REG_CRC_POLY = 8'd0;
  localparam logic [7:0] REG_CRC_INIT = 8'd1;
  localparam logic [7:0] REG_LEN_LOW  = 8'd2;
  localparam logic [7:0] REG_LEN_HIGH = 8'd3;

  // Reset values of configuration registers
  localparam logic [7:0] CRC_POLY_RST = 8'h07;
  localparam logic [7:0] CRC_INIT_RST = 8'h00;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,   // one status-only result
    CMD_DATA   = 2'd1,   // store a data byte, then one status-only result
    CMD_FRAME  = 2'd2    // emit the stored frame
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              err;
    logic [7:0]        data;
    logic [POS_W-1:0]  addr;
    logic [7:0]        id;
    logic [LEN_W-1:0]  len;
    logic [7:0]        ovr;
  } cmd_t;

  // CRC8, MSB first, one byte
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/crc8_frame_parser_top.sv
// CRC8 length-prefixed frame parser.
// Input channel: in_valid/in_ready with rx_byte, one received byte per request.
// Output channel: out_valid/out_ready, one result per request. Every byte gives
// one status-only result, except the CRC byte of a good frame of length L > 0,
// which gives L results carrying the stored data bytes in order.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0..3 selects
// polynomial, initial CRC, lengths of ids 0-7, lengths of ids 8-15; other
// indexes are ignored. Write only while no results are outstanding.
// A status result is registered in the command queue, then in the output
// register; a frame run byte also passes the data store read register; the run
// then gives one byte per cycle while out_ready is high. Throughput: the
// parser takes one byte per cycle into a 4-entry queue while it is not full;
// the emitter pops one command per cycle outside a run while out_ready is high.
// Reset (rst, synchronous): parser to idle, counters and queue cleared,
// config back to polynomial 0x07, initial 0, all lengths 0.
// When the receiver stalls, the output register holds; the queue fills and
// in_ready drops once it holds four commands.
module crc8_frame_parser_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_index,
  input  logic [63:0]                cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       frame_ok,
  output logic [7:0]                 frame_id,
  output logic [cfp_pkg::LEN_W-1:0]  frame_length,
  output logic [cfp_pkg::POS_W-1:0]  byte_position,
  output logic [7:0]                 data_byte,
  output logic                       byte_present,
  output logic                       run_last,
  output logic                       parse_error,
  output logic [7:0]                 overrun_total
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  cfp_pkg::cmd_t  q_in;
  cfp_pkg::cmd_t  q_head;

  // Parser front end
  cfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  // Command queue
  cfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Result emitter with frame data store
  cfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_ok      (frame_ok),
    .frame_id      (frame_id),
    .frame_length  (frame_length),
    .byte_position (byte_position),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .run_last      (run_last),
    .parse_error   (parse_error),
    .overrun_total (overrun_total)
  );

endmodule

// File: hdl/cfp_front.sv
module cfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output cfp_pkg::cmd_t       q_cmd
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_START  = 5'b00010,
    PH_LENGTH = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CRC    = 5'b10000
  } phase_t;

  phase_t                      phase, phase_next;
  logic [cfp_pkg::LEN_W-1:0]   exp_len, exp_len_next;
  logic [7:0]                  cur_id, cur_id_next;
  logic [cfp_pkg::LEN_W-1:0]   fill, fill_next;
  logic [7:0]                  crc, crc_next;
  logic [7:0]                  ovr, ovr_next;
  logic [7:0]                  crc_poly;
  logic [7:0]                  crc_init;
  logic [63:0]                 len_low;
  logic [63:0]                 len_high;
  logic                        accept;
  logic [63:0]                 tbl_word;
  logic [7:0]                  tbl_len;
  logic [7:0]                  crc_in;
  logic [7:0]                  crc_out;
  logic [cfp_pkg::LEN_W-1:0]   fill_inc;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;

  // Expected length lookup for the id byte
  assign tbl_word = rx_byte[3] ? len_high : len_low;
  assign tbl_len  = tbl_word[{rx_byte[2:0], 3'b000} +: 8];

  // One CRC unit, fed from the init value on the length byte
  assign crc_in   = (phase == PH_START) ? crc_init : crc;
  assign crc_out  = cfp_pkg::crc_feed(crc_in, rx_byte, crc_poly);
  assign fill_inc = fill + 1'b1;

  // Parser next state and command
  always_comb begin
    phase_next   = phase;
    exp_len_next = exp_len;
    cur_id_next  = cur_id;
    fill_next    = fill;
    crc_next     = crc;
    ovr_next     = ovr;
    q_cmd        = '0;
    q_cmd.kind   = cfp_pkg::CMD_STATUS;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == cfp_pkg::START_BYTE) begin
          phase_next   = PH_START;
          exp_len_next = '0;
        end
      end
      PH_START: begin
        if (rx_byte > 8'(cfp_pkg::MAX_DATA)) begin
          ovr_next   = ovr + 8'd1;
          q_cmd.err  = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          exp_len_next = rx_byte[cfp_pkg::LEN_W-1:0];
          fill_next    = '0;
          crc_next     = crc_out;
          phase_next   = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (rx_byte >= 8'(cfp_pkg::ID_COUNT) || tbl_len != 8'(exp_len)) begin
          q_cmd.err  = 1'b1;
          phase_next = (rx_byte == cfp_pkg::START_BYTE) ? PH_START : PH_IDLE;
        end else begin
          cur_id_next = rx_byte;
          crc_next    = crc_out;
          phase_next  = (exp_len == '0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        q_cmd.kind = cfp_pkg::CMD_DATA;
        q_cmd.data = rx_byte;
        q_cmd.addr = fill[cfp_pkg::POS_W-1:0];
        crc_next   = crc_out;
        fill_next  = fill_inc;
        if (fill_inc >= exp_len) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        if (rx_byte != crc) begin
          q_cmd.err  = 1'b1;
          phase_next = (rx_byte == cfp_pkg::START_BYTE) ? PH_START : PH_IDLE;
        end else begin
          q_cmd.kind = cfp_pkg::CMD_FRAME;
          q_cmd.id   = cur_id;
          q_cmd.len  = exp_len;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    q_cmd.ovr = ovr_next;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      exp_len <= '0;
      cur_id  <= '0;
      fill    <= '0;
      crc     <= '0;
      ovr     <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      exp_len <= exp_len_next;
      cur_id  <= cur_id_next;
      fill    <= fill_next;
      crc     <= crc_next;
      ovr     <= ovr_next;
    end
  end

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly <= cfp_pkg::CRC_POLY_RST;
      crc_init <= cfp_pkg::CRC_INIT_RST;
      len_low  <= '0;
      len_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfp_pkg::REG_CRC_POLY: crc_poly <= cfg_data[7:0];
        cfp_pkg::REG_CRC_INIT: crc_init <= cfg_data[7:0];
        cfp_pkg::REG_LEN_LOW:  len_low  <= cfg_data;
        cfp_pkg::REG_LEN_HIGH: len_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/cfp_queue.sv
module cfp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cfp_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output cfp_pkg::cmd_t  head,
  output logic           empty
);

  cfp_pkg::cmd_t             entries [cfp_pkg::Q_DEPTH];
  logic [cfp_pkg::Q_AW-1:0]  wr_ptr;
  logic [cfp_pkg::Q_AW-1:0]  rd_ptr;
  logic [cfp_pkg::Q_AW:0]    count;

  assign full  = (count == (cfp_pkg::Q_AW+1)'(cfp_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/cfp_back.sv
module cfp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  cfp_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       frame_ok,
  output logic [7:0]                 frame_id,
  output logic [cfp_pkg::LEN_W-1:0]  frame_length,
  output logic [cfp_pkg::POS_W-1:0]  byte_position,
  output logic [7:0]                 data_byte,
  output logic                       byte_present,
  output logic                       run_last,
  output logic                       parse_error,
  output logic [7:0]                 overrun_total
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } bstate_t;

  bstate_t                    state;
  logic [7:0]                 mem [cfp_pkg::MAX_DATA];
  logic [7:0]                 rd_data;
  logic [cfp_pkg::POS_W-1:0]  rd_addr;
  logic                       mem_we;
  logic                       mem_re;
  logic                       out_free;
  logic                       start_emit;
  logic                       emit_step;
  logic                       emit_last;
  logic [cfp_pkg::POS_W-1:0]  em_pos;
  logic [cfp_pkg::LEN_W-1:0]  em_len;
  logic [7:0]                 em_id;
  logic [7:0]                 em_ovr;

  // Control decode
  always_comb begin
    out_free   = !out_valid || out_ready;
    q_pop      = (state == B_IDLE) && !q_empty && out_free;
    mem_we     = q_pop && (q_head.kind == cfp_pkg::CMD_DATA);
    start_emit = q_pop && (q_head.kind == cfp_pkg::CMD_FRAME) && (q_head.len != '0);
    emit_step  = (state == B_EMIT) && out_free;
    emit_last  = ((cfp_pkg::LEN_W'(em_pos) + 1'b1) == em_len);
    mem_re     = start_emit || (emit_step && !emit_last);
    rd_addr    = start_emit ? '0 : em_pos + 1'b1;
  end

  // Frame data store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.addr] <= q_head.data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Emitter state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && !start_emit) begin
        out_valid <= 1'b1;
      end else if (emit_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: if (start_emit) state <= B_EMIT;
        B_EMIT: if (emit_step && emit_last) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // Run bookkeeping
  always_ff @(posedge clk) begin
    if (start_emit) begin
      em_pos <= '0;
      em_len <= q_head.len;
      em_id  <= q_head.id;
      em_ovr <= q_head.ovr;
    end else if (emit_step) begin
      em_pos <= em_pos + 1'b1;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (q_pop && !start_emit) begin
      frame_ok      <= (q_head.kind == cfp_pkg::CMD_FRAME);
      frame_id      <= (q_head.kind == cfp_pkg::CMD_FRAME) ? q_head.id : 8'd0;
      frame_length  <= '0;
      byte_position <= '0;
      data_byte     <= '0;
      byte_present  <= 1'b0;
      run_last      <= 1'b1;
      parse_error   <= q_head.err;
      overrun_total <= q_head.ovr;
    end else if (emit_step) begin
      frame_ok      <= 1'b1;
      frame_id      <= em_id;
      frame_length  <= em_len;
      byte_position <= em_pos;
      data_byte     <= rd_data;
      byte_present  <= 1'b1;
      run_last      <= emit_last;
      parse_error   <= 1'b0;
      overrun_total <= em_ovr;
    end
  end

`ifndef ASSERT_OFF
  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_present |-> frame_ok && !parse_error)
    else $error("data byte outside a good frame");
  a_pos_in_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_present |-> cfp_pkg::LEN_W'(byte_position) < frame_length)
    else $error("byte position beyond frame length");
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_present |-> frame_length == '0 && run_last)
    else $error("status result carries run fields");
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> cfp_pkg::LEN_W'(em_pos) < em_len)
    else $error("emitter ran past frame end");
  a_no_pop_emit: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> !q_pop)
    else $error("queue popped during a run");
`endif

endmodule
